>>> src/window_first_negative_top_defines.svh
// ----------------------------------------------------------------------------
// window_first_negative_top_defines
// assertion macros used by the checker file of the block
// ----------------------------------------------------------------------------
`ifndef WINDOW_FIRST_NEGATIVE_TOP_DEFINES_SVH
`define WINDOW_FIRST_NEGATIVE_TOP_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define WFN_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define WFN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/wfn_pkg.sv
// ----------------------------------------------------------------------------
// wfn_pkg
// shared constants and types of the sliding-window first-negative block
// ----------------------------------------------------------------------------
package wfn_pkg;

   localparam int WINDOW_MAX_DEFAULT  = 64;
   localparam int SAMPLE_BITS_DEFAULT = 32;

   // window size register
   localparam int                  CFG_BITS          = 7;
   localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RESET = 7'd3;

   // broadcast from the top level to every cell of the queue row
   typedef struct packed {
      logic advance;   // a sample transfer happens this cycle
      logic push;      // the sample is negative and goes into the queue
      logic pop;       // the head entry leaves the queue
      logic clear;     // end of sequence, the whole queue empties
   } ctrl_type;

endpackage

>>> src/window_first_negative_top.sv
// ----------------------------------------------------------------------------
// window_first_negative_top
// oldest negative sample in a sliding window over a sample stream
// ----------------------------------------------------------------------------
// Takes one sample per clock unless the output buffer is full and, once
// window_size samples of the current sequence have arrived, returns one
// result per sample through the output buffer: the oldest negative sample
// still in the window, or zero with the none_in_window flag set. Negatives
// sit in a row of WINDOW_MAX cells that shifts toward the head as entries
// expire, so no sample waits on its value; the queue push, the head compare
// and the pop all resolve in the cycle of the sample transfer. A two-entry
// output buffer keeps input transfers going while a result waits. A sample
// with tlast ends the sequence and empties the window. The window size
// register holds 0..127; 0 is read as 1, above WINDOW_MAX as WINDOW_MAX.
// ----------------------------------------------------------------------------
module window_first_negative_top
   import wfn_pkg::*;
#(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   localparam int DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   // sample input
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_BITS-1:0] req_tdata,    // sample
   input  logic                 req_tlast,    // last_sample
   // result output
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_BITS-1:0] rsp_tdata,    // first_negative
   output logic                 rsp_tuser,    // none_in_window
   // window size register
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CFG_BITS-1:0]  csr_wdata     // window_size
);

   localparam int W_BITS       = $clog2(WINDOW_MAX + 1);
   localparam int PAYLOAD_BITS = DATA_BITS + 1;

   logic [CFG_BITS-1:0]    window_size_ff, window_size_in;
   logic [W_BITS-1:0]      fill_ff, fill_in;
   logic [W_BITS-1:0]      fill_next;
   logic [W_BITS-1:0]      win_eff;
   logic                   accept;
   logic [SAMPLE_BITS-1:0] sample;
   logic                   produced;
   logic                   head_valid;
   logic [W_BITS-1:0]      head_age;
   logic [SAMPLE_BITS-1:0] head_value;
   logic [PAYLOAD_BITS-1:0] result;
   ctrl_type               ctrl;

   logic                   cell_valid [WINDOW_MAX];
   logic [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX];
   logic [W_BITS-1:0]      cell_age   [WINDOW_MAX];

   assign csr_ready = 1'b1;
   assign accept    = req_tvalid && req_tready;
   assign sample    = req_tdata[SAMPLE_BITS-1:0];

   always_comb begin
      window_size_in = window_size_ff;
      if (csr_valid && csr_ready) begin
         window_size_in = csr_wdata;
      end
   end

   always_comb begin
      if (window_size_ff == '0) begin
         win_eff = W_BITS'(1);
      end else if (32'(window_size_ff) > WINDOW_MAX) begin
         win_eff = W_BITS'(WINDOW_MAX);
      end else begin
         win_eff = W_BITS'(window_size_ff);
      end
   end

   assign fill_next = (fill_ff < W_BITS'(WINDOW_MAX)) ? fill_ff + W_BITS'(1) : fill_ff;
   assign produced  = fill_next >= win_eff;

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         fill_in = req_tlast ? '0 : fill_next;
      end
   end

   // the new sample is the head when the queue is empty
   always_comb begin
      ctrl.advance = accept;
      ctrl.clear   = req_tlast;
      ctrl.push    = sample[SAMPLE_BITS-1] && !cell_valid[WINDOW_MAX-1];
      head_valid   = cell_valid[0] || ctrl.push;
      head_age     = cell_valid[0] ? cell_age[0] : '0;
      head_value   = cell_valid[0] ? cell_value[0] : sample;
      ctrl.pop     = produced && head_valid && (head_age >= win_eff - W_BITS'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
         fill_ff        <= '0;
      end else begin
         window_size_ff <= window_size_in;
         fill_ff        <= fill_in;
      end
   end

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic                   prev_valid;
      logic                   next_valid;
      logic [SAMPLE_BITS-1:0] next_value;
      logic [W_BITS-1:0]      next_age;

      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_prev
         assign prev_valid = cell_valid[i-1];
      end

      if (i == WINDOW_MAX - 1) begin : g_last
         assign next_valid = 1'b0;
         assign next_value = '0;
         assign next_age   = '0;
      end else begin : g_next
         assign next_valid = cell_valid[i+1];
         assign next_value = cell_value[i+1];
         assign next_age   = cell_age[i+1];
      end

      wfn_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .AGE_BITS    (W_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_valid (prev_valid),
         .next_valid (next_valid),
         .next_value (next_value),
         .next_age   (next_age),
         .new_value  (sample),
         .valid      (cell_valid[i]),
         .value      (cell_value[i]),
         .age        (cell_age[i])
      );
   end

   assign result = head_valid ? {1'b0, DATA_BITS'(head_value)}
                              : {1'b1, {DATA_BITS{1'b0}}};

   wfn_out_buf #(
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && produced),
      .push_data (result),
      .ready     (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  ({rsp_tuser, rsp_tdata})
   );

endmodule

>>> src/wfn_cell.sv
// ----------------------------------------------------------------------------
// wfn_cell
// one slot of the negative-sample queue: value, age and valid flag
// ----------------------------------------------------------------------------
module wfn_cell
   import wfn_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   parameter int AGE_BITS    = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_type               ctrl,
   input  logic                   prev_valid,
   input  logic                   next_valid,
   input  logic [SAMPLE_BITS-1:0] next_value,
   input  logic [AGE_BITS-1:0]    next_age,
   input  logic [SAMPLE_BITS-1:0] new_value,
   output logic                   valid,
   output logic [SAMPLE_BITS-1:0] value,
   output logic [AGE_BITS-1:0]    age
);

   logic                   valid_ff, valid_in;
   logic [SAMPLE_BITS-1:0] value_ff, value_in;
   logic [AGE_BITS-1:0]    age_ff,   age_in;
   logic [AGE_BITS-1:0]    own_age_inc, next_age_inc;

   // ages saturate; anything at or above the largest window compares the same
   assign own_age_inc  = (&age_ff)   ? age_ff   : age_ff + AGE_BITS'(1);
   assign next_age_inc = (&next_age) ? next_age : next_age + AGE_BITS'(1);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      age_in   = age_ff;
      if (ctrl.advance) begin
         if (ctrl.clear) begin
            valid_in = 1'b0;
         end else if (ctrl.pop) begin
            // whole row moves one place toward the head
            if (next_valid) begin
               valid_in = 1'b1;
               value_in = next_value;
               age_in   = next_age_inc;
            end else if (valid_ff && ctrl.push) begin
               valid_in = 1'b1;
               value_in = new_value;
               age_in   = AGE_BITS'(1);
            end else begin
               valid_in = 1'b0;
            end
         end else begin
            if (valid_ff) begin
               age_in = own_age_inc;
            end else if (ctrl.push && prev_valid) begin
               // first empty slot takes the new negative
               valid_in = 1'b1;
               value_in = new_value;
               age_in   = AGE_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      age_ff   <= age_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign age   = age_ff;

endmodule

>>> src/wfn_out_buf.sv
// ----------------------------------------------------------------------------
// wfn_out_buf
// output register with one skid slot on the result side
// ----------------------------------------------------------------------------
module wfn_out_buf
   import wfn_pkg::*;
#(
   parameter int PAYLOAD_BITS = SAMPLE_BITS_DEFAULT + 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [PAYLOAD_BITS-1:0] push_data,
   output logic                    ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [PAYLOAD_BITS-1:0] out_data
);

   logic                    main_valid_ff, main_valid_in;
   logic                    skid_valid_ff, skid_valid_in;
   logic [PAYLOAD_BITS-1:0] main_data_ff,  main_data_in;
   logic [PAYLOAD_BITS-1:0] skid_data_ff,  skid_data_in;
   logic                    pop;

   assign pop = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_data_in = skid_data_ff;
            if (push) begin
               skid_data_in = push_data;
            end else begin
               skid_valid_in = 1'b0;
            end
         end else if (push) begin
            main_data_in = push_data;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign ready     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

>>> src/wfn_checker.sv
// ----------------------------------------------------------------------------
// wfn_checker
// port-level checks of the window first-negative block, bound to the top
// ----------------------------------------------------------------------------
`include "window_first_negative_top_defines.svh"

module wfn_checker
   import wfn_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   parameter int DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [DATA_BITS-1:0] rsp_tdata,
   input logic                 rsp_tuser
);

   // an empty window reports zero
   `WFN_ASSERT_SAME(a_none_is_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "empty window result is not zero")

   // a reported sample is always negative
   `WFN_ASSERT_SAME(a_found_is_negative, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[SAMPLE_BITS-1], "reported sample is not negative")

   // input only stalls when a result is already waiting
   `WFN_ASSERT_SAME(a_stall_has_result, clock, reset, !req_tready, rsp_tvalid, "input stalled with no pending result")

   // a stalled result holds
   `WFN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

endmodule

bind window_first_negative_top wfn_checker #(
   .SAMPLE_BITS (SAMPLE_BITS),
   .DATA_BITS   (DATA_BITS)
) u_wfn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
